[src/lph_pkg.sv]
`default_nettype none

package lph_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;    // capture input word, seed the mixer
    logic    mix_step;   // one shift-add-xor round
    logic    mul;        // golden-ratio multiply, seed the reducer
    logic    mod_step;   // one reduction step
    logic    load_home;  // probe pointer <= home slot
    logic    adv;        // step to the next slot
    logic    clear;      // clear the used bit at the pointer, advance
    logic    wr_key;     // write key and mark used at the pointer
    logic    wr_val;     // write value at the pointer
    logic    inc_count;  // one more entry
    logic    set_res;    // latch the result of this item
    logic    res_hit;    // result carries the stored value
    status_t res_status;
    logic    load_out;   // move result into the output register
  } lph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_put;
    logic mix_last;
    logic mod_last;
    logic used_q;
    logic key_eq;
    logic last_probe;
    logic last_pos;
    logic count_zero;
  } lph_sts_t;

endpackage

`default_nettype wire

[src/lph_ctrl.sv]
`default_nettype none

module lph_ctrl
  import lph_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire lph_sts_t sts,
  output lph_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MIX   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.last_pos) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_last) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          cmd.load_home = 1'b1;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.op_put) begin
          if (!sts.used_q) begin
            cmd.wr_key    = 1'b1;
            cmd.wr_val    = 1'b1;
            cmd.inc_count = 1'b1;
            cmd.set_res   = 1'b1;
            state_nxt     = S_FIN;
          end else if (sts.key_eq) begin
            cmd.wr_val  = 1'b1;
            cmd.set_res = 1'b1;
            state_nxt   = S_FIN;
          end else if (sts.last_probe) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_FIN;
          end else begin
            cmd.adv = 1'b1;
          end
        end else begin
          if (sts.used_q && sts.key_eq) begin
            cmd.set_res = 1'b1;
            cmd.res_hit = 1'b1;
            state_nxt   = S_FIN;
          end else if (sts.last_probe || sts.count_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_MISSING;
            state_nxt      = S_FIN;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/lph_dp.sv]
`default_nettype none

module lph_dp
  import lph_pkg::*;
#(
  parameter int NUM_SLOTS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lph_cmd_t           cmd,
  output lph_sts_t                sts,
  input  wire logic               in_op,
  input  wire logic signed [31:0] in_key,
  input  wire logic signed [31:0] in_value,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_read_value
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);
  localparam bit IS_POW2 = ((NUM_SLOTS & (NUM_SLOTS - 1)) == 0);

  logic               op_r;
  logic signed [31:0] key_r, val_r;
  logic [31:0]        x_r, x_nxt, t_mix;
  logic [1:0]         rnd_r;
  logic [31:0]        prod;
  logic [AW-1:0]      home;
  logic               mod_last;
  logic [AW-1:0]      pos_r, pos_nxt, pos_inc;
  logic [AW-1:0]      cnt_r;
  logic [CW-1:0]      count_r;
  logic               used_q_r;
  logic [31:0]        key_q_r;
  logic signed [31:0] val_q_r;
  status_t            res_status_r;
  logic signed [31:0] res_value_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_value_r;

  logic               used_mem [NUM_SLOTS];
  logic [31:0]        key_mem  [NUM_SLOTS];
  logic signed [31:0] val_mem  [NUM_SLOTS];

  // One mixing round: add a left shift, then fold in a right shift
  always_comb begin
    case (rnd_r)
      2'd0: begin
        t_mix = x_r + (x_r << 12);
        x_nxt = t_mix ^ (t_mix >> 22);
      end
      2'd1: begin
        t_mix = x_r + (x_r << 4);
        x_nxt = t_mix ^ (t_mix >> 9);
      end
      2'd2: begin
        t_mix = x_r + (x_r << 10);
        x_nxt = t_mix ^ (t_mix >> 2);
      end
      default: begin
        t_mix = x_r + (x_r << 7);
        x_nxt = t_mix ^ (t_mix >> 12);
      end
    endcase
  end

  assign prod = {3'b000, x_r[31:3]} * HASH_MULT;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
      x_r   <= in_key;
      rnd_r <= 2'd0;
    end else if (cmd.mix_step) begin
      x_r   <= x_nxt;
      rnd_r <= rnd_r + 2'd1;
    end
  end

  // Home slot: mask for a power-of-two table, else restoring reduction
  // one shifted divisor per cycle
  if (IS_POW2) begin : g_mod_mask
    logic [31:0] rem_r;

    always_ff @(posedge clk) begin
      if (cmd.mul) rem_r <= prod;
    end

    assign home     = rem_r[AW-1:0];
    assign mod_last = 1'b1;
  end else begin : g_mod_div
    localparam int MSH    = 33 - AW;
    localparam int MSTEPS = MSH + 1;
    localparam int MW     = $clog2(MSTEPS);
    localparam logic [32:0] DSR_INIT = 33'(NUM_SLOTS) << MSH;

    logic [31:0]   rem_r, rem_nxt;
    logic [32:0]   dsr_r;
    logic [MW-1:0] mstep_r;

    always_comb begin
      rem_nxt = rem_r;
      if ({1'b0, rem_r} >= dsr_r) rem_nxt = rem_r - dsr_r[31:0];
    end

    always_ff @(posedge clk) begin
      if (cmd.mul) begin
        rem_r   <= prod;
        dsr_r   <= DSR_INIT;
        mstep_r <= '0;
      end else if (cmd.mod_step) begin
        rem_r   <= rem_nxt;
        dsr_r   <= dsr_r >> 1;
        mstep_r <= mstep_r + 1'b1;
      end
    end

    assign home     = rem_nxt[AW-1:0];
    assign mod_last = (mstep_r == MW'(MSTEPS - 1));
  end

  // Probe pointer; the memories read at its next value so that the
  // registered read data always belongs to pos_r
  assign pos_inc = (pos_r == LAST) ? '0 : pos_r + 1'b1;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load_home) pos_nxt = home;
    else if (cmd.adv || cmd.clear) pos_nxt = pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cmd.inc_count) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_home) cnt_r <= '0;
    else if (cmd.adv) cnt_r <= cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) used_mem[pos_r] <= 1'b0;
    else if (cmd.wr_key) used_mem[pos_r] <= 1'b1;
    used_q_r <= used_mem[pos_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key) key_mem[pos_r] <= key_r;
    key_q_r <= key_mem[pos_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_val) val_mem[pos_r] <= val_r;
    val_q_r <= val_mem[pos_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= cmd.res_hit ? val_q_r : '0;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign sts.op_put     = op_r;
  assign sts.mix_last   = (rnd_r == 2'd3);
  assign sts.mod_last   = mod_last;
  assign sts.used_q     = used_q_r;
  assign sts.key_eq     = (key_q_r == key_r);
  assign sts.last_probe = (cnt_r == LAST);
  assign sts.last_pos   = (pos_r == LAST);
  assign sts.count_zero = (count_r == '0);

  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule

`default_nettype wire

[src/linear_probe_hash_table_top.sv]
`default_nettype none

// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   tuser: op; tdata: key, value
// out_     master     out_tvalid / out_tready tuser: status; tdata: read_value
//
// A word passes from accept through mixing, multiply, reduction and probing to hand-over;
// reduction is a mask for a power-of-two NUM_SLOTS, else one step per cycle. From 1 to
// NUM_SLOTS slots are probed, one per cycle; a get miss probes all of them (one while empty).
// After reset a clearing pass over all NUM_SLOTS slots resets the used bits; in_tready is low.
// A waiting result holds in the output register while the next word is worked on; that
// word stalls in its last cycle until the first result is taken.

module linear_probe_hash_table_top
  import lph_pkg::*;
#(
  parameter int NUM_SLOTS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  wire logic [0:0]  in_tuser,   // [0] op: 0 get, 1 put
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] read_value
  output logic [1:0]       out_tuser   // [1:0] status
);

  lph_cmd_t           cmd;
  lph_sts_t           sts;
  logic signed [31:0] read_value;

  // Sequencer: clearing pass, mix, multiply, reduce, probe, hand over
  lph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hash unit, slot memories, entry count and result registers
  lph_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_tuser[0]),
    .in_key         (in_tdata[31:0]),
    .in_value       (in_tdata[63:32]),
    .out_status     (out_tuser),
    .out_read_value (read_value)
  );

  assign out_tdata = read_value;

endmodule

`default_nettype wire
